/* hdl/vef_pkg.sv */
package vef_pkg;

	localparam int MAX_RUN    = 32;
	localparam int PEND_DEPTH = MAX_RUN - 1;
	localparam int RUN_W      = $clog2(MAX_RUN + 1);
	localparam int PEND_W     = $clog2(MAX_RUN);
	localparam int ADDR_W     = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
	localparam int PIX_W      = 8;
	localparam int LIMIT_W    = 6;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic             done;
		logic             last;
	} result_t;

endpackage

/* hdl/vef_pend_ram.sv */
module vef_pend_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [vef_pkg::ADDR_W-1:0]  waddr,
	input  logic [vef_pkg::PIX_W-1:0]   wdata,
	input  logic [vef_pkg::ADDR_W-1:0]  raddr,
	output logic [vef_pkg::PIX_W-1:0]   rdata
);

	logic [vef_pkg::PIX_W-1:0] mem [vef_pkg::PEND_DEPTH];
	logic [vef_pkg::PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we && (32'(waddr) < 32'(vef_pkg::PEND_DEPTH))) begin
			mem[waddr] <= wdata;
		end
		// addresses past the last entry are only prefetched, never used
		if (32'(raddr) < 32'(vef_pkg::PEND_DEPTH)) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/vef_seq.sv */
module vef_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        lim_we,
	input  logic [vef_pkg::LIMIT_W-1:0] lim_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [vef_pkg::PIX_W-1:0]   pixel_value,
	input  logic                        column_end,
	input  logic                        res_ready,
	output logic                        res_push,
	output vef_pkg::result_t            res,
	output logic                        ram_we,
	output logic [vef_pkg::ADDR_W-1:0]  ram_waddr,
	output logic [vef_pkg::PIX_W-1:0]   ram_wdata,
	output logic [vef_pkg::ADDR_W-1:0]  ram_raddr,
	input  logic [vef_pkg::PIX_W-1:0]   ram_rdata
);

	vef_pkg::seq_state_t state_q, state_d;

	logic [vef_pkg::LIMIT_W-1:0] lim_q;
	logic [vef_pkg::RUN_W-1:0]   run_q;
	logic [vef_pkg::PEND_W-1:0]  pend_q;
	logic [vef_pkg::PEND_W-1:0]  idx_q;
	logic [vef_pkg::PEND_W-1:0]  cnt_q;
	logic                        keep_q;
	logic [vef_pkg::PIX_W-1:0]   fin_val_q;
	logic                        fin_done_q;

	logic [vef_pkg::RUN_W-1:0]   lim_eff;
	logic [vef_pkg::RUN_W-1:0]   run_inc;
	logic                        accept;
	logic                        is_zero;
	logic                        keep_now;
	logic                        produce;
	logic                        in_pending;
	logic [vef_pkg::PEND_W-1:0]  idx_next;

	always_comb begin
		if (lim_q == '0) begin
			lim_eff = vef_pkg::RUN_W'(1);
		end else if (32'(lim_q) > 32'(vef_pkg::MAX_RUN)) begin
			lim_eff = vef_pkg::RUN_W'(vef_pkg::MAX_RUN);
		end else begin
			lim_eff = vef_pkg::RUN_W'(lim_q);
		end
	end

	assign run_inc  = (32'(run_q) < 32'(vef_pkg::MAX_RUN)) ? run_q + 1'b1 : run_q;
	assign accept   = in_valid && (state_q == vef_pkg::ST_IDLE);
	assign is_zero  = (pixel_value == '0);
	assign keep_now = !is_zero && (run_inc >= lim_eff);
	assign produce  = is_zero || keep_now || column_end;

	assign in_pending = (idx_q < cnt_q);
	assign idx_next   = idx_q + 1'b1;

	// short run member goes to the pending store
	assign ram_we    = accept && !produce;
	assign ram_waddr = vef_pkg::ADDR_W'(pend_q);
	assign ram_wdata = pixel_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vef_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		res_push  = 1'b0;
		ram_raddr = '0;
		res.value = fin_val_q;
		res.done  = fin_done_q;
		res.last  = 1'b1;
		case (state_q)
			vef_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (accept && produce) begin
					state_d = vef_pkg::ST_EMIT;
				end
			end
			vef_pkg::ST_EMIT: begin
				res_push = res_ready;
				// look one entry ahead so read data lines up with the index
				ram_raddr = vef_pkg::ADDR_W'(res_ready ? idx_next : idx_q);
				if (in_pending) begin
					res.value = keep_q ? ram_rdata : '0;
					res.done  = 1'b0;
					res.last  = 1'b0;
				end else if (res_ready) begin
					state_d = vef_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vef_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q  <= vef_pkg::LIMIT_RESET;
			run_q  <= '0;
			pend_q <= '0;
			idx_q  <= '0;
			cnt_q  <= '0;
		end else begin
			if (lim_we) begin
				lim_q <= lim_wdata;
			end
			if (accept) begin
				if (produce) begin
					run_q  <= (is_zero || column_end) ? '0 : run_inc;
					cnt_q  <= pend_q;
					idx_q  <= '0;
					pend_q <= '0;
				end else begin
					run_q <= run_inc;
					if (32'(pend_q) < 32'(vef_pkg::PEND_DEPTH)) begin
						pend_q <= pend_q + 1'b1;
					end
				end
			end else if (state_q == vef_pkg::ST_EMIT && res_ready && in_pending) begin
				idx_q <= idx_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && produce) begin
			keep_q     <= keep_now;
			fin_val_q  <= keep_now ? pixel_value : '0;
			fin_done_q <= column_end;
		end
	end

endmodule

/* hdl/vef_out_reg.sv */
module vef_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vef_pkg::result_t res,
	output logic             ready,
	output logic             out_valid,
	input  logic             out_stall,
	output vef_pkg::result_t res_q
);

	logic valid_q;

	assign ready     = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

endmodule

/* hdl/vertical_edge_run_filter_core.sv */
// vertical run filter for a column-major edge map
// input channel: in_valid / in_stall with pixel_value and column_end, one pixel per
// transaction; output channel: out_valid / out_stall with kept_value, column_done and
// last_of_burst, one result per pixel, always in input order.
// run_limit is written with run_limit_we while the block is idle.
// a nonzero pixel of a run still shorter than the limit is parked in the pending
// memory and gives no result of its own yet. a pixel that ends or completes a run
// starts a burst: the sequencer drains the pending memory one entry per cycle while
// the output register is not stalled, through its single read port, then sends
// the pixel's own result, flagged last_of_burst. the first result of a burst passes
// through the sequencer's emit state register and then the output register.
// in_stall stays high while a burst drains; the output register holds its result
// while out_stall is high and the drain pauses with it. an item is still taken
// while the last result of the previous burst waits in the output register.
// reset clears the run, the pending count and the output valid, and sets run_limit
// to 8; the pending memory needs no clearing.
module vertical_edge_run_filter_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        run_limit_we,
	input  logic [vef_pkg::LIMIT_W-1:0] run_limit,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [vef_pkg::PIX_W-1:0]   pixel_value,
	input  logic                        column_end,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [vef_pkg::PIX_W-1:0]   kept_value,
	output logic                        column_done,
	output logic                        last_of_burst
);

	vef_pkg::result_t res;
	vef_pkg::result_t res_q;
	logic             res_push;
	logic             res_ready;

	logic                       ram_we;
	logic [vef_pkg::ADDR_W-1:0] ram_waddr;
	logic [vef_pkg::PIX_W-1:0]  ram_wdata;
	logic [vef_pkg::ADDR_W-1:0] ram_raddr;
	logic [vef_pkg::PIX_W-1:0]  ram_rdata;

	vef_pend_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	vef_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.lim_we      (run_limit_we),
		.lim_wdata   (run_limit),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_value (pixel_value),
		.column_end  (column_end),
		.res_ready   (res_ready),
		.res_push    (res_push),
		.res         (res),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	vef_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.res       (res),
		.ready     (res_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign kept_value    = res_q.value;
	assign column_done   = res_q.done;
	assign last_of_burst = res_q.last;

endmodule

/* hdl/vef_port_chk.sv */
module vef_port_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic [vef_pkg::PIX_W-1:0] pixel_value,
	input logic                      column_end,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [vef_pkg::PIX_W-1:0] kept_value,
	input logic                      column_done,
	input logic                      last_of_burst
);

	// a held result keeps its valid and its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kept_value)
			&& $stable(column_done) && $stable(last_of_burst))
		else $error("output changed while stalled");

	// a column only closes on the final result of a burst
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && column_done |-> last_of_burst)
		else $error("column_done on a non-final result");

	// a pixel that ends a run starts a burst, so input is held off next cycle
	a_burst_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (pixel_value == '0 || column_end) |=> in_stall)
		else $error("input taken during a burst");

endmodule

bind vertical_edge_run_filter_core vef_port_chk u_port_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.pixel_value   (pixel_value),
	.column_end    (column_end),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.kept_value    (kept_value),
	.column_done   (column_done),
	.last_of_burst (last_of_burst)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int N_PHASES      = 10;
	localparam int PHASE_ITEMS   = 44;
	localparam int N_DIR         = 29;

	typedef enum logic {
		ROW_PIX,
		ROW_CFG
	} row_kind_t;

	// how a generated run of edge pixels is closed
	typedef enum int {
		RUN_TO_ZERO,
		RUN_TO_COL_END,
		RUN_OPEN
	} run_close_t;

	typedef struct packed {
		row_kind_t    kind;
		logic [7:0]   data;
		logic         col_end;
		logic         has_exp;
		logic [7:0]   t_value;
		logic         t_done;
	} stim_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          run_limit_we;
	logic [vef_pkg::LIMIT_W-1:0]   run_limit;
	logic                          in_valid;
	logic                          in_stall;
	logic [vef_pkg::PIX_W-1:0]     pixel_value;
	logic                          column_end;
	logic                          out_valid;
	logic                          out_stall;
	logic [vef_pkg::PIX_W-1:0]     kept_value;
	logic                          column_done;
	logic                          last_of_burst;

	// side info that travels with each pixel transaction
	logic                          row_has_exp;
	logic [vef_pkg::PIX_W-1:0]     row_tval;
	logic                          row_tdone;

	bit                            failed = 1'b0;
	bit                            hold_off = 1'b0;
	bit                            quiet_sender = 1'b0;
	logic [vef_pkg::LIMIT_W-1:0]   set_limit = vef_pkg::LIMIT_RESET;

	// filter state mirrored by the checker
	logic [vef_pkg::LIMIT_W-1:0]   limit_copy = vef_pkg::LIMIT_RESET;
	int                            run_len = 0;
	logic [vef_pkg::PIX_W-1:0]     parked_px [$];
	vef_pkg::result_t              filtered_q [$];

	stim_row_t dir_rows [N_DIR] = '{
		'{ROW_PIX, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
		'{ROW_PIX, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1},
		'{ROW_PIX, 8'hff, 1'b1, 1'b1, 8'h00, 1'b1},
		'{ROW_PIX, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'h02, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'h04, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'h08, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'h10, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'h20, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'h40, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
		'{ROW_PIX, 8'h7f, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'hfe, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'h33, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'h11, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'h22, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'h44, 1'b1, 1'b0, 8'h00, 1'b0},
		'{ROW_CFG, 8'd0,  1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'haa, 1'b0, 1'b1, 8'haa, 1'b0},
		'{ROW_PIX, 8'h55, 1'b1, 1'b1, 8'h55, 1'b1},
		'{ROW_CFG, 8'd63, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'hff, 1'b1, 1'b1, 8'h00, 1'b1},
		'{ROW_CFG, 8'd32, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'h9c, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'h63, 1'b0, 1'b0, 8'h00, 1'b0},
		// limit drops while two pixels are parked
		'{ROW_CFG, 8'd2,  1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_PIX, 8'hc5, 1'b0, 1'b0, 8'h00, 1'b0}
	};

	logic [vef_pkg::LIMIT_W-1:0] phase_limit [N_PHASES] = '{
		6'd5, 6'd1, 6'd32, 6'd2, 6'd63, 6'd12, 6'd0, 6'd3, 6'd33, 6'd4
	};

	vertical_edge_run_filter_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.run_limit_we  (run_limit_we),
		.run_limit     (run_limit),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pixel_value   (pixel_value),
		.column_end    (column_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kept_value    (kept_value),
		.column_done   (column_done),
		.last_of_burst (last_of_burst)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 24);
	endfunction

	task automatic queue_result(input logic [7:0] v, input logic d, input logic l);
		vef_pkg::result_t r;
		r.value = v;
		r.done  = d;
		r.last  = l;
		filtered_q.insert(filtered_q.size(), r);
	endtask

	task automatic release_parked(input logic keep);
		foreach (parked_px[i])
			queue_result(keep ? parked_px[i] : 8'h00, 1'b0, 1'b0);
		parked_px.delete();
	endtask

	task automatic filter_pixel(input logic [7:0] px, input logic ce, input logic has_exp,
			input logic [7:0] tv, input logic td);
		int lim;
		int base;
		base = filtered_q.size();
		if (limit_copy == 0)
			lim = 1;
		else if (limit_copy > vef_pkg::MAX_RUN)
			lim = vef_pkg::MAX_RUN;
		else
			lim = int'(limit_copy);
		if (px == 8'h00) begin
			release_parked(1'b0);
			queue_result(8'h00, ce, 1'b1);
			run_len = 0;
		end else begin
			if (run_len < vef_pkg::MAX_RUN)
				run_len++;
			if (run_len >= lim) begin
				release_parked(1'b1);
				queue_result(px, ce, 1'b1);
			end else if (ce) begin
				release_parked(1'b0);
				queue_result(8'h00, 1'b1, 1'b1);
			end else if (parked_px.size() < vef_pkg::PEND_DEPTH) begin
				parked_px.insert(parked_px.size(), px);
			end
		end
		if (ce) begin
			run_len = 0;
			parked_px.delete();
		end
		// rows with a hand-written answer replace what was just worked out
		if (has_exp) begin
			while (filtered_q.size() > base)
				void'(filtered_q.pop_back());
			queue_result(tv, td, 1'b1);
		end
	endtask

	always @(posedge clk) begin
		vef_pkg::result_t exp;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (filtered_q.size() == 0) begin
					$error("unexpected result: kept_value %0d column_done %0d last_of_burst %0d",
						kept_value, column_done, last_of_burst);
					failed = 1'b1;
				end else begin
					exp = filtered_q.pop_front();
					if (kept_value !== exp.value) begin
						$error("kept_value: expected %0d, got %0d", exp.value, kept_value);
						failed = 1'b1;
					end
					if (column_done !== exp.done) begin
						$error("column_done: expected %0d, got %0d", exp.done, column_done);
						failed = 1'b1;
					end
					if (last_of_burst !== exp.last) begin
						$error("last_of_burst: expected %0d, got %0d", exp.last, last_of_burst);
						failed = 1'b1;
					end
				end
			end
			if (run_limit_we)
				limit_copy = run_limit;
			if (in_valid && !in_stall)
				filter_pixel(pixel_value, column_end, row_has_exp, row_tval, row_tdone);
		end
	end

	task automatic send_pixel(input logic [7:0] px, input logic ce, input logic has_exp,
			input logic [7:0] tv, input logic td);
		int gap;
		gap = quiet_sender ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		pixel_value <= px;
		column_end  <= ce;
		row_has_exp <= has_exp;
		row_tval    <= tv;
		row_tdone   <= td;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		int waited;
		@(negedge clk);
		in_valid <= 1'b0;
		waited = 0;
		while (filtered_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (filtered_q.size() != 0) begin
			$error("%0d expected results never arrived", filtered_q.size());
			failed = 1'b1;
			filtered_q.delete();
		end
		// a parked pixel gives no result but may still be in flight
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [vef_pkg::LIMIT_W-1:0] v);
		wait_drained();
		run_limit_we <= 1'b1;
		run_limit    <= v;
		set_limit = v;
		@(negedge clk);
		run_limit_we <= 1'b0;
	endtask

	task automatic random_phase(input int n_items);
		int sent;
		int len;
		int lim_eff;
		run_close_t close_kind;
		if (set_limit == 0)
			lim_eff = 1;
		else if (set_limit > vef_pkg::MAX_RUN)
			lim_eff = vef_pkg::MAX_RUN;
		else
			lim_eff = int'(set_limit);
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) < 8) begin
				// a run of edge pixels of about the limit's length
				len = lim_eff + $urandom_range(0, 6) - 3;
				if ($urandom_range(0, 7) == 0)
					len = $urandom_range(1, vef_pkg::MAX_RUN + 4);
				if (len < 1)
					len = 1;
				if (len > n_items - sent)
					len = n_items - sent;
				close_kind = run_close_t'($urandom_range(0, 2));
				for (int k = 0; k < len; k++)
					send_pixel(8'($urandom_range(1, 255)),
						(close_kind == RUN_TO_COL_END) && (k == len - 1), 1'b0, 8'h00, 1'b0);
				sent += len;
				if (close_kind == RUN_TO_ZERO && sent < n_items) begin
					send_pixel(8'h00, 1'($urandom_range(0, 1)), 1'b0, 8'h00, 1'b0);
					sent++;
				end
			end else begin
				send_pixel(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 3) == 0), 1'b0, 8'h00, 1'b0);
				sent++;
			end
		end
	endtask

	// receiver side
	initial begin
		int gap;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_off = 1'b0;
			end else if ($urandom_range(0, 24) == 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(20, 60)) @(negedge clk);
			end else begin
				gap = idle_len();
				out_stall <= (gap != 0);
				if (gap > 1)
					repeat (gap - 1) @(negedge clk);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		run_limit_we = 1'b0;
		run_limit    = vef_pkg::LIMIT_RESET;
		in_valid     = 1'b0;
		pixel_value  = '0;
		column_end   = 1'b0;
		row_has_exp  = 1'b0;
		row_tval     = '0;
		row_tdone    = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_limit(dir_rows[i].data[vef_pkg::LIMIT_W-1:0]);
			else
				send_pixel(dir_rows[i].data, dir_rows[i].col_end, dir_rows[i].has_exp,
					dir_rows[i].t_value, dir_rows[i].t_done);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			write_limit((p == N_PHASES - 1) ? 6'($urandom_range(0, 63)) : phase_limit[p]);
			quiet_sender = (p % 3 == 2);
			// output held off for a long stretch while pixels keep coming
			if (p == 3)
				hold_off = 1'b1;
			random_phase(PHASE_ITEMS);
		end

		wait_drained();
		if (!failed)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
